[sv/ctdq_pkg.sv]
package ctdq_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;

   localparam int GAIN_W      = 40;
   localparam int STEP_W      = 38;
   localparam int SEED_W      = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 40;

   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int FULL_W = PROD_W + 2;
   localparam int X_W    = 48;
   localparam int RND_W  = 24;
   localparam int C_W    = 16;
   localparam int SUM_W  = 18;

   localparam int T_SHIFT   = SAMPLE_BITS - 16;
   localparam int OUT_SHIFT = 41 - SAMPLE_BITS;
   localparam int STEP_SPLIT = 20;

   localparam int Q_ONE    = 65536;
   localparam int Q_HALF   = 32768;
   localparam int AWAY_Q   = 25100;
   localparam int PHI_Q    = 106040;
   localparam int OMEGA_Q  = 37168;
   localparam int EXPC_Q   = 4325;
   localparam int TINY_MUL = 55723;
   localparam int C_MAX    = OMEGA_Q + EXPC_Q;

   localparam logic [SEED_W-1:0] SEED_MIN   = 32'd16386;
   localparam logic [SEED_W-1:0] SEED_RESET = 32'd2463534242;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 40'h80_0000_0000;
   localparam logic [STEP_W-1:0] STEP_RESET = 38'd131072;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INPUT_GAIN  = 2'd0,
      CSR_OUTPUT_STEP = 2'd1,
      CSR_NOISE_SEED  = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_MAG_HI,
      S_MAG_LO,
      S_MAG_SUM,
      S_TINY_P,
      S_TINY_LO,
      S_TINY_HI,
      S_TINY_SUM,
      S_ERR,
      S_CURVE,
      S_COEF,
      S_SHAPE,
      S_MIX,
      S_APPLY,
      S_LEVEL,
      S_OUT_LO,
      S_OUT_HI,
      S_RESULT
   } state_type;

   function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] v);
      logic [SEED_W-1:0] a;
      logic [SEED_W-1:0] b;
      a = v ^ (v << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

endpackage

[sv/contingent_tpdf_dither_quantizer.sv]
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+---------------------------------------
// req_      | in        | req_tvalid/req_tready | tdata: sample_in
// rsp_      | out       | rsp_tvalid/rsp_tready | tdata: dithered_sample, tuser: clipped
// csr_      | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// A zero sample takes a longer path through the states than others. One 33x33 signed multiplier is
// shared by every product, one product per cycle, under the state sequencer.
// req_tready is high only in the idle state; csr_ready is always high.
// The result sits in an output register, so the next request is taken while it waits.
// A finished request holds in its last state until the output register is free.
// Synchronous reset sets control registers and the noise state (to the seed), not datapath.
module contingent_tpdf_dither_quantizer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [ctdq_pkg::DATA_W-1:0]           req_tdata,   // sample_in
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [ctdq_pkg::DATA_W-1:0]           rsp_tdata,   // dithered_sample
   output logic                                  rsp_tuser,   // clipped
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ctdq_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ctdq_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int SB = ctdq_pkg::SAMPLE_BITS;

   ctdq_pkg::state_type state_ff, state_in;

   logic [ctdq_pkg::GAIN_W-1:0]           gain_ff, gain_in;
   logic [ctdq_pkg::STEP_W-1:0]           step_ff, step_in;
   logic [ctdq_pkg::SEED_W-1:0]           ns_ff, ns_in;
   logic [15:0]                           pe_ff, pe_in;
   logic                                  flip_ff, flip_in;

   logic [SB-1:0]                         mag_ff, mag_in;
   logic                                  neg_ff, neg_in;
   logic signed [ctdq_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic signed [ctdq_pkg::X_W-1:0]       x_ff, x_in;
   logic signed [ctdq_pkg::RND_W-1:0]     rnd_ff, rnd_in;
   logic [ctdq_pkg::C_W-1:0]              c_ff, c_in;
   logic signed [ctdq_pkg::PROD_W-1:0]    acc_ff, acc_in;
   logic signed [ctdq_pkg::PROD_W-1:0]    prod_ff, prod_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]                         out_ff, out_in;
   logic                                  clip_ff, clip_in;

   logic signed [ctdq_pkg::MUL_W-1:0]     mul_a, mul_b;

   logic signed [SB-1:0]                  s_in;
   logic [ctdq_pkg::SEED_W-1:0]           ns_next;
   logic [ctdq_pkg::PROD_W-1:0]           t_sum;
   logic [ctdq_pkg::X_W-1:0]              t_mag;
   logic [34:0]                           tiny_sum;
   logic [ctdq_pkg::X_W-1:0]              tiny_x;
   logic [ctdq_pkg::X_W-1:0]              x_abs;
   logic [17:0]                           ct2;
   logic [17:0]                           cterm;
   logic [16:0]                           one_minus_c;
   logic signed [ctdq_pkg::RND_W-1:0]     c_signed;
   logic signed [ctdq_pkg::X_W-17:0]      level;
   logic signed [ctdq_pkg::FULL_W-1:0]    full;
   logic signed [ctdq_pkg::FULL_W-1:0]    res;
   logic                                  out_free;

   assign s_in      = req_tdata[SB-1:0];
   assign ns_next   = ctdq_pkg::xorshift(ns_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign prod_in   = mul_a * mul_b;

   assign t_sum     = (ctdq_pkg::PROD_W'(acc_ff) << 5) + (ctdq_pkg::PROD_W'(prod_ff) >> 15);
   assign t_mag     = ctdq_pkg::X_W'(t_sum >> ctdq_pkg::T_SHIFT);
   assign tiny_sum  = 35'(prod_ff[33:0]) + 35'(acc_ff[16:0]);
   assign tiny_x    = ctdq_pkg::X_W'(tiny_sum[34:16]);
   assign x_abs     = x_ff[ctdq_pkg::X_W-1] ? ctdq_pkg::X_W'(-x_ff) : ctdq_pkg::X_W'(x_ff);
   assign ct2       = {1'b0, pe_ff, 1'b0};
   assign cterm     = (ct2 > 18'(ctdq_pkg::Q_ONE)) ? 18'(2 * ctdq_pkg::Q_ONE) - ct2 : ct2;
   assign one_minus_c = 17'(ctdq_pkg::Q_ONE) - {1'b0, c_ff};
   assign c_signed  = $signed(ctdq_pkg::RND_W'(c_ff));
   assign level     = x_ff[ctdq_pkg::X_W-1:16];
   assign full      = (ctdq_pkg::FULL_W'(prod_ff) <<< ctdq_pkg::STEP_SPLIT)
                      + ctdq_pkg::FULL_W'(acc_ff);
   assign res       = full >>> ctdq_pkg::OUT_SHIFT;

   assign req_tready = (state_ff == ctdq_pkg::S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ctdq_pkg::DATA_W'(out_ff);
   assign rsp_tuser  = clip_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ctdq_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = (s_in == '0) ? ctdq_pkg::S_TINY_P : ctdq_pkg::S_MAG_HI;
            end
         end
         ctdq_pkg::S_MAG_HI:   state_in = ctdq_pkg::S_MAG_LO;
         ctdq_pkg::S_MAG_LO:   state_in = ctdq_pkg::S_MAG_SUM;
         ctdq_pkg::S_MAG_SUM:  state_in = ctdq_pkg::S_ERR;
         ctdq_pkg::S_TINY_P:   state_in = ctdq_pkg::S_TINY_LO;
         ctdq_pkg::S_TINY_LO:  state_in = ctdq_pkg::S_TINY_HI;
         ctdq_pkg::S_TINY_HI:  state_in = ctdq_pkg::S_TINY_SUM;
         ctdq_pkg::S_TINY_SUM: state_in = ctdq_pkg::S_ERR;
         ctdq_pkg::S_ERR:      state_in = ctdq_pkg::S_CURVE;
         ctdq_pkg::S_CURVE:    state_in = ctdq_pkg::S_COEF;
         ctdq_pkg::S_COEF:     state_in = ctdq_pkg::S_SHAPE;
         ctdq_pkg::S_SHAPE:    state_in = ctdq_pkg::S_MIX;
         ctdq_pkg::S_MIX:      state_in = ctdq_pkg::S_APPLY;
         ctdq_pkg::S_APPLY:    state_in = ctdq_pkg::S_LEVEL;
         ctdq_pkg::S_LEVEL:    state_in = ctdq_pkg::S_OUT_LO;
         ctdq_pkg::S_OUT_LO:   state_in = ctdq_pkg::S_OUT_HI;
         ctdq_pkg::S_OUT_HI:   state_in = ctdq_pkg::S_RESULT;
         ctdq_pkg::S_RESULT: begin
            if (out_free) begin
               state_in = ctdq_pkg::S_IDLE;
            end
         end
         default:              state_in = ctdq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      gain_in      = gain_ff;
      step_in      = step_ff;
      ns_in        = ns_ff;
      pe_in        = pe_ff;
      flip_in      = flip_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      sum_in       = sum_ff;
      x_in         = x_ff;
      rnd_in       = rnd_ff;
      c_in         = c_ff;
      acc_in       = acc_ff;
      out_in       = out_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mul_a        = '0;
      mul_b        = '0;

      if (csr_valid) begin
         case (csr_index)
            ctdq_pkg::CSR_INPUT_GAIN:  gain_in = csr_data[ctdq_pkg::GAIN_W-1:0];
            ctdq_pkg::CSR_OUTPUT_STEP: step_in = csr_data[ctdq_pkg::STEP_W-1:0];
            ctdq_pkg::CSR_NOISE_SEED: begin
               if (csr_data[ctdq_pkg::SEED_W-1:0] >= ctdq_pkg::SEED_MIN) begin
                  ns_in = csr_data[ctdq_pkg::SEED_W-1:0];
               end
            end
            default: ;
         endcase
      end

      case (state_ff)
         ctdq_pkg::S_IDLE: begin
            mag_in = s_in[SB-1] ? SB'(-s_in) : SB'(s_in);
            neg_in = s_in[SB-1];
            sum_in = $signed(ctdq_pkg::SUM_W'(ns_ff[31:16]))
                     + $signed(ctdq_pkg::SUM_W'(ns_next[31:16]))
                     - ctdq_pkg::SUM_W'(ctdq_pkg::Q_ONE);
         end
         ctdq_pkg::S_MAG_HI: begin
            mul_a = ctdq_pkg::MUL_W'(mag_ff);
            mul_b = ctdq_pkg::MUL_W'(gain_ff[39:20]);
         end
         ctdq_pkg::S_MAG_LO: begin
            mul_a  = ctdq_pkg::MUL_W'(mag_ff);
            mul_b  = ctdq_pkg::MUL_W'(gain_ff[19:0]);
            acc_in = prod_ff;
         end
         ctdq_pkg::S_MAG_SUM: begin
            if (t_mag == '0) begin
               x_in = '0;
            end else if (neg_ff) begin
               x_in = -$signed(t_mag + ctdq_pkg::X_W'(ctdq_pkg::AWAY_Q));
            end else begin
               x_in = $signed(t_mag + ctdq_pkg::X_W'(ctdq_pkg::AWAY_Q));
            end
            mul_a = ctdq_pkg::MUL_W'(sum_ff);
            mul_b = ctdq_pkg::MUL_W'(ctdq_pkg::PHI_Q);
         end
         ctdq_pkg::S_TINY_P: begin
            mul_a = ctdq_pkg::MUL_W'(ns_ff);
            mul_b = ctdq_pkg::MUL_W'(gain_ff[39:8]);
         end
         ctdq_pkg::S_TINY_LO: begin
            mul_a  = ctdq_pkg::MUL_W'(prod_ff[47:16]);
            mul_b  = ctdq_pkg::MUL_W'(ctdq_pkg::TINY_MUL);
            acc_in = ctdq_pkg::PROD_W'(prod_ff[63:48]);
         end
         ctdq_pkg::S_TINY_HI: begin
            mul_a  = ctdq_pkg::MUL_W'(acc_ff[15:0]);
            mul_b  = ctdq_pkg::MUL_W'(ctdq_pkg::TINY_MUL);
            acc_in = ctdq_pkg::PROD_W'(prod_ff[47:32]);
         end
         ctdq_pkg::S_TINY_SUM: begin
            x_in  = (tiny_x == '0) ? '0 : $signed(tiny_x + ctdq_pkg::X_W'(ctdq_pkg::AWAY_Q));
            mul_a = ctdq_pkg::MUL_W'(sum_ff);
            mul_b = ctdq_pkg::MUL_W'(ctdq_pkg::PHI_Q);
         end
         ctdq_pkg::S_ERR: begin
            rnd_in = ctdq_pkg::RND_W'(prod_ff >>> 16);
            mul_a  = ctdq_pkg::MUL_W'(pe_ff);
            mul_b  = ctdq_pkg::MUL_W'(ctdq_pkg::OMEGA_Q);
            pe_in  = x_abs[15:0];
            ns_in  = ns_next;
         end
         ctdq_pkg::S_CURVE: begin
            rnd_in = rnd_ff - ctdq_pkg::RND_W'(prod_ff >>> 16);
            mul_a  = ctdq_pkg::MUL_W'(cterm);
            mul_b  = ctdq_pkg::MUL_W'(ctdq_pkg::OMEGA_Q);
         end
         ctdq_pkg::S_COEF: begin
            c_in = ctdq_pkg::C_W'(prod_ff >>> 16) + ctdq_pkg::C_W'(ctdq_pkg::EXPC_Q);
         end
         ctdq_pkg::S_SHAPE: begin
            mul_a = ctdq_pkg::MUL_W'(rnd_ff);
            mul_b = ctdq_pkg::MUL_W'(one_minus_c);
         end
         ctdq_pkg::S_MIX: begin
            rnd_in  = ctdq_pkg::RND_W'(prod_ff >>> 16)
                      + (flip_ff ? c_signed : -c_signed)
                      + ctdq_pkg::RND_W'(ctdq_pkg::Q_HALF);
            flip_in = !flip_ff;
         end
         ctdq_pkg::S_APPLY: begin
            mul_a = ctdq_pkg::MUL_W'(rnd_ff);
            mul_b = ctdq_pkg::MUL_W'(c_ff);
         end
         ctdq_pkg::S_LEVEL: begin
            x_in = x_ff + ctdq_pkg::X_W'(prod_ff >>> 16);
         end
         ctdq_pkg::S_OUT_LO: begin
            mul_a = ctdq_pkg::MUL_W'(level);
            mul_b = ctdq_pkg::MUL_W'(step_ff[ctdq_pkg::STEP_SPLIT-1:0]);
         end
         ctdq_pkg::S_OUT_HI: begin
            mul_a  = ctdq_pkg::MUL_W'(level);
            mul_b  = ctdq_pkg::MUL_W'(step_ff[ctdq_pkg::STEP_W-1:ctdq_pkg::STEP_SPLIT]);
            acc_in = prod_ff;
         end
         ctdq_pkg::S_RESULT: begin
            if (out_free) begin
               if (res > ctdq_pkg::FULL_W'(ctdq_pkg::SAMPLE_MAX)) begin
                  out_in  = ctdq_pkg::SAMPLE_MAX;
                  clip_in = 1'b1;
               end else if (res < ctdq_pkg::FULL_W'(ctdq_pkg::SAMPLE_MIN)) begin
                  out_in  = ctdq_pkg::SAMPLE_MIN;
                  clip_in = 1'b1;
               end else begin
                  out_in  = SB'(res);
                  clip_in = 1'b0;
               end
               rsp_valid_in = 1'b1;
               ns_in        = ns_next;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctdq_pkg::S_IDLE;
         gain_ff      <= ctdq_pkg::GAIN_RESET;
         step_ff      <= ctdq_pkg::STEP_RESET;
         ns_ff        <= ctdq_pkg::SEED_RESET;
         pe_ff        <= '0;
         flip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         step_ff      <= step_in;
         ns_ff        <= ns_in;
         pe_ff        <= pe_in;
         flip_ff      <= flip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      sum_ff  <= sum_in;
      x_ff    <= x_in;
      rnd_ff  <= rnd_in;
      c_ff    <= c_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      out_ff  <= out_in;
      clip_ff <= clip_in;
   end

   a_accept_path: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=>
         (state_ff == ctdq_pkg::S_MAG_HI || state_ff == ctdq_pkg::S_TINY_P))
      else $error("request did not start a magnitude product");

   a_noise_nonzero: assert property (@(posedge clock) disable iff (reset)
      ns_ff != '0)
      else $error("noise generator reached the all-zero state");

   a_flip_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ctdq_pkg::S_MIX) |=> (flip_ff != $past(flip_ff)))
      else $error("sign phase did not alternate");

   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ctdq_pkg::S_APPLY) |->
         (c_ff >= ctdq_pkg::C_W'(ctdq_pkg::EXPC_Q) && c_ff <= ctdq_pkg::C_W'(ctdq_pkg::C_MAX)))
      else $error("shaping coefficient out of range");

   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (out_ff == ctdq_pkg::SAMPLE_MAX || out_ff == ctdq_pkg::SAMPLE_MIN))
      else $error("clip flag set on an unsaturated result");

endmodule
